// ----- hdl/ima_adpcm_block_decoder_defines.svh -----
// Assertion macros shared by the checker of the IMA ADPCM block decoder.
// Depends on nothing; included by files that assert.
`ifndef IMA_ADPCM_BLOCK_DECODER_DEFINES_SVH
`define IMA_ADPCM_BLOCK_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define IMADEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("imadec same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define IMADEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("imadec next-cycle check failed");

`endif

// ----- hdl/imadec_pkg.sv -----
// Types, constants and nibble-decode functions for the IMA ADPCM block decoder.
// Depends on nothing.
package imadec_pkg;

	localparam logic [6:0] STEP_MAX = 7'd88;
	localparam logic [3:0] NIB_MASK = 4'hF;

	// Result of decoding one nibble
	typedef struct packed {
		logic signed [15:0] pred;
		logic [6:0]         idx;
	} dec_t;

	// Standard IMA step size table
	function automatic logic [14:0] step_size(logic [6:0] pos);
		logic [14:0] s;
		case (pos)
			7'd0: s = 15'd7;       7'd1: s = 15'd8;       7'd2: s = 15'd9;
			7'd3: s = 15'd10;      7'd4: s = 15'd11;      7'd5: s = 15'd12;
			7'd6: s = 15'd13;      7'd7: s = 15'd14;      7'd8: s = 15'd16;
			7'd9: s = 15'd17;      7'd10: s = 15'd19;     7'd11: s = 15'd21;
			7'd12: s = 15'd23;     7'd13: s = 15'd25;     7'd14: s = 15'd28;
			7'd15: s = 15'd31;     7'd16: s = 15'd34;     7'd17: s = 15'd37;
			7'd18: s = 15'd41;     7'd19: s = 15'd45;     7'd20: s = 15'd50;
			7'd21: s = 15'd55;     7'd22: s = 15'd60;     7'd23: s = 15'd66;
			7'd24: s = 15'd73;     7'd25: s = 15'd80;     7'd26: s = 15'd88;
			7'd27: s = 15'd97;     7'd28: s = 15'd107;    7'd29: s = 15'd118;
			7'd30: s = 15'd130;    7'd31: s = 15'd143;    7'd32: s = 15'd157;
			7'd33: s = 15'd173;    7'd34: s = 15'd190;    7'd35: s = 15'd209;
			7'd36: s = 15'd230;    7'd37: s = 15'd253;    7'd38: s = 15'd279;
			7'd39: s = 15'd307;    7'd40: s = 15'd337;    7'd41: s = 15'd371;
			7'd42: s = 15'd408;    7'd43: s = 15'd449;    7'd44: s = 15'd494;
			7'd45: s = 15'd544;    7'd46: s = 15'd598;    7'd47: s = 15'd658;
			7'd48: s = 15'd724;    7'd49: s = 15'd796;    7'd50: s = 15'd876;
			7'd51: s = 15'd963;    7'd52: s = 15'd1060;   7'd53: s = 15'd1166;
			7'd54: s = 15'd1282;   7'd55: s = 15'd1411;   7'd56: s = 15'd1552;
			7'd57: s = 15'd1707;   7'd58: s = 15'd1878;   7'd59: s = 15'd2066;
			7'd60: s = 15'd2272;   7'd61: s = 15'd2499;   7'd62: s = 15'd2749;
			7'd63: s = 15'd3024;   7'd64: s = 15'd3327;   7'd65: s = 15'd3660;
			7'd66: s = 15'd4026;   7'd67: s = 15'd4428;   7'd68: s = 15'd4871;
			7'd69: s = 15'd5358;   7'd70: s = 15'd5894;   7'd71: s = 15'd6484;
			7'd72: s = 15'd7132;   7'd73: s = 15'd7845;   7'd74: s = 15'd8630;
			7'd75: s = 15'd9493;   7'd76: s = 15'd10442;  7'd77: s = 15'd11487;
			7'd78: s = 15'd12635;  7'd79: s = 15'd13899;  7'd80: s = 15'd15289;
			7'd81: s = 15'd16818;  7'd82: s = 15'd18500;  7'd83: s = 15'd20350;
			7'd84: s = 15'd22385;  7'd85: s = 15'd24623;  7'd86: s = 15'd27086;
			7'd87: s = 15'd29794;
			default: s = 15'd32767;
		endcase
		return s;
	endfunction

	// Step index adjustment by the magnitude bits
	function automatic logic signed [4:0] index_move(logic [2:0] mag);
		logic signed [4:0] m;
		case (mag)
			3'd4: m = 5'sd2;
			3'd5: m = 5'sd4;
			3'd6: m = 5'sd6;
			3'd7: m = 5'sd8;
			default: m = -5'sd1;
		endcase
		return m;
	endfunction

	// One nibble: new predictor (saturated) and new step index (clamped)
	function automatic dec_t decode_nibble(logic signed [15:0] pred, logic [6:0] pos_in,
			logic [3:0] nib);
		logic [6:0]         pos;
		logic [14:0]        step;
		logic signed [8:0]  idx;
		logic signed [4:0]  mv;
		logic [16:0]        diff;
		logic signed [17:0] nxt;
		dec_t               r;
		pos  = (pos_in > STEP_MAX) ? STEP_MAX : pos_in;
		step = step_size(pos);
		mv   = index_move(nib[2:0]);
		idx  = $signed({2'b00, pos}) + $signed({{4{mv[4]}}, mv});
		if (idx < 0) begin
			r.idx = 7'd0;
		end else if (idx > $signed({2'b00, STEP_MAX})) begin
			r.idx = STEP_MAX;
		end else begin
			r.idx = idx[6:0];
		end
		// Difference built from the step and its shifted copies
		diff = {5'b0, step[14:3]};
		if (nib[2]) diff = diff + {2'b0, step};
		if (nib[1]) diff = diff + {3'b0, step[14:1]};
		if (nib[0]) diff = diff + {4'b0, step[14:2]};
		if (nib[3]) begin
			nxt = $signed({{2{pred[15]}}, pred}) - $signed({1'b0, diff});
		end else begin
			nxt = $signed({{2{pred[15]}}, pred}) + $signed({1'b0, diff});
		end
		if (nxt > 18'sd32767) begin
			r.pred = 16'sh7FFF;
		end else if (nxt < -18'sd32768) begin
			r.pred = 16'sh8000;
		end else begin
			r.pred = nxt[15:0];
		end
		return r;
	endfunction

endpackage

// ----- hdl/ima_adpcm_block_decoder.sv -----
// IMA ADPCM block decoder top level; uses imadec_pkg.
// Path: an accepted byte sits in the input item register; samples leave via the result
// register. Throughput: one nibble per cycle unless out_stall holds it; a data byte
// is low then high nibble (low only if it ends an even block), other beats one step.
// Reset (arst_n low, asynchronous) clears all control state, predictor, step index,
// block position and block_samples; no clearing pass is needed.
module ima_adpcm_block_decoder (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        block_samples,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [7:0]         data_byte,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample,
	output logic               from_header,
	output logic               last
);

	localparam logic [1:0] HDR_PRED_LO = 2'd0;
	localparam logic [1:0] HDR_PRED_HI = 2'd1;
	localparam logic [1:0] HDR_STEP    = 2'd2;
	localparam logic [1:0] HDR_RSVD    = 2'd3;

	logic [15:0]        block_samples_q;
	logic signed [15:0] pred_q;
	logic [6:0]         idx_q;
	logic [1:0]         hdr_cnt_q;
	logic [15:0]        left_q;

	logic               item_v_s1;
	logic               action_s1;
	logic [7:0]         byte_s1;
	logic               phase_q;

	logic               out_valid_q;
	logic signed [15:0] sample_q;
	logic               from_header_q;
	logic               last_q;

	logic               out_free;
	logic               raw_mode;
	logic [3:0]         cur_nib;
	imadec_pkg::dec_t   dec;
	logic [15:0]        left_m1;
	logic               needs_out;
	logic               item_done;
	logic               step_en;
	logic signed [15:0] pred_d;
	logic [6:0]         idx_d;
	logic [1:0]         hdr_cnt_d;
	logic [15:0]        left_d;
	logic signed [15:0] o_sample;
	logic               o_hdr;
	logic               o_last;

	// Configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_samples_q <= '0;
		end else if (cfg_valid) begin
			block_samples_q <= block_samples;
		end
	end

	// Decode unit on the current nibble
	assign out_free = !out_valid_q || !out_stall;
	assign raw_mode = (block_samples_q == 16'd0);
	assign cur_nib  = (phase_q ? byte_s1[7:4] : byte_s1[3:0]) & imadec_pkg::NIB_MASK;
	assign dec      = imadec_pkg::decode_nibble(pred_q, idx_q, cur_nib);
	assign left_m1  = left_q - 16'd1;

	// Next state and result for one step of the held item
	always_comb begin
		pred_d    = pred_q;
		idx_d     = idx_q;
		hdr_cnt_d = hdr_cnt_q;
		left_d    = left_q;
		needs_out = 1'b0;
		item_done = 1'b1;
		o_sample  = dec.pred;
		o_hdr     = 1'b0;
		o_last    = 1'b1;
		if (action_s1) begin
			pred_d    = '0;
			idx_d     = '0;
			hdr_cnt_d = HDR_PRED_LO;
			left_d    = '0;
		end else if (phase_q) begin
			// high nibble of a data byte
			pred_d    = dec.pred;
			idx_d     = dec.idx;
			needs_out = 1'b1;
			if (!raw_mode) begin
				left_d = left_m1;
			end
		end else if (raw_mode) begin
			pred_d    = dec.pred;
			idx_d     = dec.idx;
			needs_out = 1'b1;
			o_last    = 1'b0;
			item_done = 1'b0;
		end else if (left_q == 16'd0) begin
			// block header bytes
			case (hdr_cnt_q)
				HDR_PRED_LO: begin
					pred_d    = {pred_q[15:8], byte_s1};
					hdr_cnt_d = HDR_PRED_HI;
				end
				HDR_PRED_HI: begin
					pred_d    = {byte_s1, pred_q[7:0]};
					hdr_cnt_d = HDR_STEP;
				end
				HDR_STEP: begin
					idx_d     = (byte_s1 > {1'b0, imadec_pkg::STEP_MAX}) ?
						imadec_pkg::STEP_MAX : byte_s1[6:0];
					hdr_cnt_d = HDR_RSVD;
				end
				default: begin
					hdr_cnt_d = HDR_PRED_LO;
					left_d    = block_samples_q - 16'd1;
					needs_out = 1'b1;
					o_sample  = pred_q;
					o_hdr     = 1'b1;
				end
			endcase
		end else begin
			// low nibble inside a block; drop the high nibble if the block ends
			pred_d    = dec.pred;
			idx_d     = dec.idx;
			left_d    = left_m1;
			needs_out = 1'b1;
			if (left_m1 != 16'd0) begin
				o_last    = 1'b0;
				item_done = 1'b0;
			end
		end
	end

	assign step_en  = item_v_s1 && (out_free || !needs_out);
	assign in_stall = item_v_s1 && !(step_en && item_done);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q    <= '0;
			idx_q     <= '0;
			hdr_cnt_q <= HDR_PRED_LO;
			left_q    <= '0;
		end else if (step_en) begin
			pred_q    <= pred_d;
			idx_q     <= idx_d;
			hdr_cnt_q <= hdr_cnt_d;
			left_q    <= left_d;
		end
	end

	// Input item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
			phase_q   <= 1'b0;
		end else if (in_valid && !in_stall) begin
			item_v_s1 <= 1'b1;
			phase_q   <= 1'b0;
		end else if (step_en && item_done) begin
			item_v_s1 <= 1'b0;
			phase_q   <= 1'b0;
		end else if (step_en) begin
			phase_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			byte_s1   <= data_byte;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && needs_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && needs_out) begin
			sample_q      <= o_sample;
			from_header_q <= o_hdr;
			last_q        <= o_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample      = sample_q;
	assign from_header = from_header_q;
	assign last        = last_q;

endmodule

// ----- hdl/imadec_checker.sv -----
// Port-level checks for the IMA ADPCM block decoder, bound to the top level.
// Depends on ima_adpcm_block_decoder_defines.svh.
`include "ima_adpcm_block_decoder_defines.svh"

module imadec_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] sample,
	input logic               from_header,
	input logic               last
);

	// A stalled output beat holds its payload
	`IMADEC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(sample) && $stable(last) && $stable(from_header))

	// A header sample is always the only sample of its byte
	`IMADEC_ASSERT_NOW(a_hdr_last, clk, arst_n, out_valid && from_header, last)

	// The second sample of a byte follows right after the first is taken
	`IMADEC_ASSERT_NEXT(a_pair_follows, clk, arst_n, out_valid && !out_stall && !last, out_valid && !from_header)

endmodule

bind ima_adpcm_block_decoder imadec_checker u_imadec_checker (.*);
